[design/pbt_pkg.sv]
// Package with the shared types, field widths and codes of the piece block tracker.
`timescale 1ns / 1ps

package pbt_pkg;

    localparam int FUNC_W   = 3;
    localparam int SHIFT_W  = 5;
    localparam int BYTES_W  = 24;
    localparam int TICKS_W  = 20;
    localparam int OFFS_W   = 24;
    localparam int LEN_W    = 17;
    localparam int STATUS_W = 3;
    localparam int RETRY_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int MAX_SHIFT  = 16;

    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ARRIVE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RETRY   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_WRITTEN = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGN  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_DONE  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIECE_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [TICKS_W-1:0] IDLE_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST
    } t_state;

    typedef struct packed {
        logic accept;
        logic step;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic has_result;
        logic last_word;
        logic out_busy;
    } t_ctl_sts;

endpackage

[design/pbt_if.sv]
// Channel interfaces of the piece block tracker: item input, result output, configuration.
`timescale 1ns / 1ps

interface pbt_in_if;
    import pbt_pkg::*;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic                mark;
    logic [OFFS_W-1:0]   byte_offset;
    logic [LEN_W-1:0]    byte_length;
    logic                written_flag;
    modport source (output valid, func, mark, byte_offset, byte_length, written_flag,
                    input ready);
    modport sink   (input valid, func, mark, byte_offset, byte_length, written_flag,
                    output ready);
endinterface

interface pbt_out_if;
    import pbt_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFFS_W-1:0]   next_offset_out;
    logic                complete;
    logic [RETRY_W-1:0]  retry_count;
    logic                from_memory;
    logic [LEN_W-1:0]    read_length;
    logic                unrequested;
    modport source (output valid, status, next_offset_out, complete, retry_count,
                    from_memory, read_length, unrequested, input ready);
    modport sink   (input valid, status, next_offset_out, complete, retry_count,
                    from_memory, read_length, unrequested, output ready);
endinterface

interface pbt_cfg_if;
    import pbt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/pbt_ctrl.sv]
// Controller state machine that sequences accept, bitmap word sweep and result load.
`timescale 1ns / 1ps

module pbt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pbt_pkg::t_ctl_sts i_sts,
    output pbt_pkg::t_ctl_cmd o_cmd
);
    import pbt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.has_result) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.last_word) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            S_POST: begin
                o_cmd.load = !i_sts.out_busy;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

[design/pbt_datapath.sv]
// Datapath with the configuration, bitmaps, idle counter, word sweep and result register.
`timescale 1ns / 1ps

module pbt_datapath #(
    parameter int MAX_BLOCKS    = 256,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [pbt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pbt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [pbt_pkg::FUNC_W-1:0]      i_func,
    input  logic                            i_mark,
    input  logic [pbt_pkg::OFFS_W-1:0]      i_byte_offset,
    input  logic [pbt_pkg::LEN_W-1:0]       i_byte_length,
    input  logic                            i_written_flag,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [pbt_pkg::STATUS_W-1:0]    o_status,
    output logic [pbt_pkg::OFFS_W-1:0]      o_next_offset_out,
    output logic                            o_complete,
    output logic [pbt_pkg::RETRY_W-1:0]     o_retry_count,
    output logic                            o_from_memory,
    output logic [pbt_pkg::LEN_W-1:0]       o_read_length,
    output logic                            o_unrequested,
    input  pbt_pkg::t_ctl_cmd               i_cmd,
    output pbt_pkg::t_ctl_sts               o_sts
);
    import pbt_pkg::*;

    localparam int WORDS  = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W  = $clog2(MAP_WORD_BITS);
    localparam int BIDX_W = $clog2(WORDS * MAP_WORD_BITS + 1);
    localparam int N_W    = $clog2(MAX_BLOCKS + 1);
    localparam int PC_W   = $clog2(MAP_WORD_BITS + 1);

    logic [SHIFT_W-1:0] r_shift;
    logic [BYTES_W-1:0] r_bytes;
    logic [TICKS_W-1:0] r_timeout;

    logic [MAP_WORD_BITS-1:0] r_req  [WORDS];
    logic [MAP_WORD_BITS-1:0] r_done [WORDS];
    logic                     r_written;
    logic                     r_active;
    logic [TICKS_W-1:0]       r_idle;

    logic [FUNC_W-1:0]   r_func;
    logic                r_mark;
    logic [OFFS_W-1:0]   r_id;
    logic [LEN_W-1:0]    r_len;
    logic [STATUS_W-1:0] r_rej;
    logic                r_go;

    logic [WORD_W-1:0]   r_ptr;
    logic                r_found;
    logic [BIDX_W-1:0]   r_idx;
    logic                r_all;
    logic                r_dup;
    logic                r_unreq;
    logic                r_rd_done;
    logic [N_W-1:0]      r_cnt;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [OFFS_W-1:0]   r_given_offset;
    logic                r_complete;
    logic [RETRY_W-1:0]  r_retry;
    logic                r_from_mem;
    logic [LEN_W-1:0]    r_read_len;
    logic                r_unrequested;

    logic [SHIFT_W-1:0]       eff_s;
    logic [LEN_W-1:0]         bsize;
    logic [LEN_W-1:0]         bmask;
    logic [BYTES_W:0]         n_raw;
    logic [N_W-1:0]           n_eff;
    logic [OFFS_W-1:0]        in_id;
    logic                     misalign;
    logic                     too_big;
    logic                     overflow;
    logic                     beyond;
    logic [STATUS_W-1:0]      n_rej;
    logic                     go_now;
    logic                     last_word;

    logic [BIDX_W-1:0]        base;
    logic [MAP_WORD_BITS-1:0] wmask;
    logic [MAP_WORD_BITS-1:0] word_req;
    logic [MAP_WORD_BITS-1:0] word_done;
    logic [MAP_WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]         fb;
    logic                     any_free;
    logic                     hit;
    logic [BIT_W-1:0]         hbit;
    logic [MAP_WORD_BITS-1:0] setmask;
    logic [PC_W-1:0]          pc;

    logic [STATUS_W-1:0]      fin_status;
    logic [39:0]              off_full;
    logic [N_W+RETRY_W-1:0]   cnt_ext;
    logic                     read_ok;

    always_comb begin
        eff_s = (r_shift > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : r_shift;
        bsize = LEN_W'(1) << eff_s;
        bmask = bsize - LEN_W'(1);
        n_raw = ({1'b0, r_bytes} + (BYTES_W + 1)'(bmask)) >> eff_s;
        n_eff = (n_raw > (BYTES_W + 1)'(MAX_BLOCKS)) ? N_W'(MAX_BLOCKS) : N_W'(n_raw);
        in_id    = i_byte_offset >> eff_s;
        misalign = (i_byte_offset & OFFS_W'(bmask)) != '0;
        too_big  = i_byte_length > bsize;
        overflow = (({1'b0, i_byte_offset} + (OFFS_W + 1)'(i_byte_length))
                    > {1'b0, r_bytes}) || ((OFFS_W + 1)'(in_id) >= (OFFS_W + 1)'(n_eff));
        beyond   = (i_byte_offset >= r_bytes) ||
                   ((OFFS_W + 1)'(in_id) >= (OFFS_W + 1)'(n_eff));
        n_rej = ST_OK;
        if (i_func == FUNC_ARRIVE) begin
            n_rej = misalign ? ST_MISALIGN : too_big ? ST_TOO_BIG :
                    overflow ? ST_OVERFLOW : ST_OK;
        end else if (i_func == FUNC_READ) begin
            n_rej = misalign ? ST_MISALIGN : beyond ? ST_OVERFLOW : ST_OK;
        end
        go_now    = !r_written && r_active && (r_idle > r_timeout);
        last_word = r_ptr == WORD_W'(WORDS - 1);
    end

    always_comb begin
        base      = BIDX_W'(r_ptr) * BIDX_W'(MAP_WORD_BITS);
        word_req  = r_req[r_ptr];
        word_done = r_done[r_ptr];
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            wmask[b] = (base + BIDX_W'(b)) < BIDX_W'(n_eff);
        end
        free_bits = ~word_req & ~word_done & wmask;
        any_free  = free_bits != '0;
        fb        = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                fb = BIT_W'(b);
            end
        end
        hit  = (r_id >= OFFS_W'(base)) &&
               (r_id < (OFFS_W'(base) + OFFS_W'(MAP_WORD_BITS)));
        hbit = BIT_W'(r_id - OFFS_W'(base));
        setmask = '0;
        if (hit && (r_rej == ST_OK)) begin
            setmask[hbit] = 1'b1;
        end
        pc = PC_W'($countones(word_req & ~word_done));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= SHIFT_W'(14);
            r_bytes     <= BYTES_W'(262144);
            r_timeout   <= TICKS_W'(30000);
            for (int w = 0; w < WORDS; w++) begin
                r_req[w]  <= '0;
                r_done[w] <= '0;
            end
            r_written   <= 1'b0;
            r_active    <= 1'b0;
            r_idle      <= '0;
            r_ptr       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BLOCK_SHIFT:   r_shift   <= i_cfg_data[SHIFT_W-1:0];
                    CFG_PIECE_BYTES:   r_bytes   <= i_cfg_data[BYTES_W-1:0];
                    CFG_TIMEOUT_TICKS: r_timeout <= i_cfg_data[TICKS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
                if ((i_func == FUNC_TICK) && r_active && (r_idle != IDLE_MAX)) begin
                    r_idle <= r_idle + TICKS_W'(1);
                end
                if ((i_func == FUNC_ARRIVE) && (n_rej == ST_OK)) begin
                    r_idle   <= '0;
                    r_active <= 1'b1;
                end
                if (i_func == FUNC_WRITTEN) begin
                    r_written <= i_written_flag;
                end
            end
            if (i_cmd.step) begin
                if (!last_word) begin
                    r_ptr <= r_ptr + WORD_W'(1);
                end
                case (r_func)
                    FUNC_REQUEST: begin
                        if (!r_found && any_free) begin
                            r_found <= 1'b1;
                            if (r_mark) begin
                                r_req[r_ptr][fb] <= 1'b1;
                                r_idle   <= '0;
                                r_active <= 1'b1;
                            end
                        end
                    end
                    FUNC_ARRIVE:  r_done[r_ptr] <= word_done | setmask;
                    FUNC_RETRY: begin
                        if (r_go) begin
                            r_req[r_ptr] <= '0;
                        end
                    end
                    FUNC_WRITTEN: r_done[r_ptr] <= word_done | wmask;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func    <= i_func;
            r_mark    <= i_mark;
            r_id      <= in_id;
            r_len     <= i_byte_length;
            r_rej     <= n_rej;
            r_go      <= go_now;
            r_all     <= 1'b1;
            r_dup     <= 1'b0;
            r_unreq   <= 1'b0;
            r_rd_done <= 1'b0;
            r_cnt     <= '0;
        end
        if (i_cmd.step) begin
            if (!r_found && any_free) begin
                r_idx <= base + BIDX_W'(fb);
            end
            r_all <= r_all && (((word_done | setmask) & wmask) == wmask);
            if (hit) begin
                r_dup     <= word_done[hbit];
                r_unreq   <= !word_req[hbit];
                r_rd_done <= word_done[hbit];
            end
            if ((r_func == FUNC_RETRY) && r_go) begin
                r_cnt <= r_cnt + N_W'(pc);
            end
        end
        if (i_cmd.load) begin
            r_status       <= fin_status;
            r_given_offset <= ((r_func == FUNC_REQUEST) && r_found) ?
                              off_full[OFFS_W-1:0] : '0;
            r_complete     <= (r_func == FUNC_ARRIVE) && (r_rej == ST_OK) && r_all;
            r_retry        <= (r_func == FUNC_RETRY) ? cnt_ext[RETRY_W-1:0] : '0;
            r_from_mem     <= read_ok && !r_written;
            r_read_len     <= read_ok ? ((r_len != '0) ? r_len : bsize) : '0;
            r_unrequested  <= (r_func == FUNC_ARRIVE) && (r_rej == ST_OK) && !r_dup && r_unreq;
        end
    end

    always_comb begin
        off_full = 40'(r_idx) << eff_s;
        cnt_ext  = (N_W + RETRY_W)'(r_cnt);
        read_ok  = (r_func == FUNC_READ) && (r_rej == ST_OK) && r_rd_done;
        fin_status = ST_OK;
        case (r_func)
            FUNC_REQUEST: fin_status = r_found ? ST_OK : ST_NONE_FREE;
            FUNC_ARRIVE:  fin_status = (r_rej != ST_OK) ? r_rej :
                                       r_dup ? ST_DUPLICATE : ST_OK;
            FUNC_READ:    fin_status = (r_rej != ST_OK) ? r_rej :
                                       r_rd_done ? ST_OK : ST_NOT_DONE;
            default:      fin_status = ST_OK;
        endcase
    end

    assign o_sts.has_result = (i_func != FUNC_TICK) && (i_func <= FUNC_WRITTEN);
    assign o_sts.last_word  = last_word;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_next_offset_out = r_given_offset;
    assign o_complete        = r_complete;
    assign o_retry_count     = r_retry;
    assign o_from_memory     = r_from_mem;
    assign o_read_length     = r_read_len;
    assign o_unrequested     = r_unrequested;

endmodule

[design/piece_block_tracker.sv]
// Top level of the piece block tracker: controller, datapath and channel wiring.
//
//  channel   dir   transaction moves
//  i_in      in    func, mark, byte_offset, byte_length, written_flag
//  o_out     out   status, next_offset_out, complete, retry_count, from_memory,
//                  read_length, unrequested
//  i_cfg     in    index, data (0 block_shift, 1 piece_bytes, 2 timeout_ticks)
//
// An item with a result goes through accept, a sweep over the WORDS bitmap words in
// turn (WORDS = MAX_BLOCKS / MAP_WORD_BITS rounded up), then the result load.
// A tick or an unused func code is accepted in the idle state and gives no result.
// Reset clears the bitmaps and the idle counter at once; there is no clearing pass.
// A result waits in the output register while the next item is accepted and swept;
// the load of the next result stalls until the output register is free.
`timescale 1ns / 1ps

module piece_block_tracker #(
    parameter int MAX_BLOCKS    = 256,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbt_in_if.sink    i_in,
    pbt_cfg_if.sink   i_cfg,
    pbt_out_if.source o_out
);
    import pbt_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;
    logic     in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    pbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pbt_datapath #(
        .MAX_BLOCKS    (MAX_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_func            (i_in.func),
        .i_mark            (i_in.mark),
        .i_byte_offset     (i_in.byte_offset),
        .i_byte_length     (i_in.byte_length),
        .i_written_flag    (i_in.written_flag),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_status          (o_out.status),
        .o_next_offset_out (o_out.next_offset_out),
        .o_complete        (o_out.complete),
        .o_retry_count     (o_out.retry_count),
        .o_from_memory     (o_out.from_memory),
        .o_read_length     (o_out.read_length),
        .o_unrequested     (o_out.unrequested),
        .i_cmd             (cmd),
        .o_sts             (sts)
    );

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !i_in.ready)
        else $error("Input accepted during a bitmap sweep.");

    a_load_not_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !(o_out.valid && !o_out.ready))
        else $error("Result loaded over a pending result.");

    a_tick_no_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.func == FUNC_TICK)) |=> !cmd.step)
        else $error("Tick started a sweep.");

    a_last_then_load_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step && sts.last_word) |=> (!cmd.step && !i_in.ready))
        else $error("Sweep did not end in the load phase.");

endmodule
